### hdl/sha1bs_pkg.sv
// SHA-1 byte stream hasher: shared types, constants and round helpers.
// No dependencies.
package sha1bs_pkg;

	localparam logic [1:0] REQ_DATA    = 2'd0;
	localparam logic [1:0] REQ_DIGEST  = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	localparam logic [31:0] H0_INIT = 32'h67452301;
	localparam logic [31:0] H1_INIT = 32'hefcdab89;
	localparam logic [31:0] H2_INIT = 32'h98badcfe;
	localparam logic [31:0] H3_INIT = 32'h10325476;
	localparam logic [31:0] H4_INIT = 32'hc3d2e1f0;

	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam int QUEUE_DEPTH = 4;

	// item handed from front end to back end
	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] data_byte;
	} cmd_t;

	typedef logic [4:0][31:0] chain_t;

	function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (t < 7'd20)      f = (b & c) | (~b & d);
		else if (t < 7'd40) f = b ^ c ^ d;
		else if (t < 7'd60) f = (b & c) | (b & d) | (c & d);
		else                f = b ^ c ^ d;
		return f;
	endfunction

	function automatic logic [31:0] round_k(input logic [6:0] t);
		logic [31:0] k;
		if (t < 7'd20)      k = K0;
		else if (t < 7'd40) k = K1;
		else if (t < 7'd60) k = K2;
		else                k = K3;
		return k;
	endfunction

endpackage

### hdl/sha1bs_front.sv
// Front end: input handshake, drops unused request codes, small command queue.
// Depends on sha1bs_pkg.
module sha1bs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  logic [1:0]          s_tuser,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output sha1bs_pkg::cmd_t    cmd
);
	localparam int AW = $clog2(sha1bs_pkg::QUEUE_DEPTH);

	sha1bs_pkg::cmd_t mem_q [sha1bs_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic push, pop, keep;

	assign s_tready  = (cnt_q != AW'(0) + (AW+1)'(sha1bs_pkg::QUEUE_DEPTH));
	assign keep      = (s_tuser == sha1bs_pkg::REQ_DATA) || (s_tuser == sha1bs_pkg::REQ_DIGEST)
		|| (s_tuser == sha1bs_pkg::REQ_RESTART);
	assign push      = s_tvalid && s_tready && keep;
	assign cmd_valid = (cnt_q != '0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q].req_type  <= s_tuser;
			mem_q[wr_q].data_byte <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + AW'(1);
			if (pop)  rd_q <= rd_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

### hdl/sha1bs_core.sv
// Back end: block buffer, message schedule, one SHA-1 round per cycle,
// padding sequencer and digest output register. Depends on sha1bs_pkg.
module sha1bs_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  sha1bs_pkg::cmd_t    cmd,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata,
	output logic                m_tlast
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1; // fill schedule window from buffer
	localparam logic [2:0] ST_RND  = 3'd2;
	localparam logic [2:0] ST_FOLD = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]  state_q;
	logic [7:0]  buf_q [64];
	logic [5:0]  nbytes_q;
	logic [54:0] blocks_q;
	sha1bs_pkg::chain_t chain_q, work_h_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [15:0][31:0] w_q;
	logic [6:0]  t_q;
	logic [5:0]  ld_q;       // byte index while loading
	logic        digest_q;   // running a digest
	logic        second_q;   // second padded block
	logic        two_q;      // digest needs two blocks
	logic [5:0]  dn_q;       // buffered bytes at digest
	logic [63:0] bits_q;
	logic [7:0]  rd_byte_s1;
	logic [5:0]  rd_idx_s1;
	logic        rd_vld_s1;
	logic [2:0]  oidx_q;

	// padded byte for position p of the current block
	function automatic logic [7:0] pad_byte(input logic [6:0] p, input logic [7:0] raw,
		input logic [5:0] n, input logic [63:0] bits, input logic two);
		logic [6:0] tot;
		logic [7:0] v;
		tot = two ? 7'd127 : 7'd63;
		if (p < {1'b0, n})            v = raw;
		else if (p == {1'b0, n})      v = sha1bs_pkg::PAD_BYTE;
		else if (p > tot - 7'd8 && p <= tot)
			v = bits[8*(tot - p) +: 8];
		else                          v = 8'h00;
		return v;
	endfunction

	logic [31:0] wnew, tmp, f, k;
	logic [7:0]  byte_in;
	logic [6:0]  pos;
	assign f = sha1bs_pkg::round_f(t_q, b_q, c_q, d_q);
	assign k = sha1bs_pkg::round_k(t_q);
	assign wnew = t_q < 7'd16 ? w_q[0] :
		{w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]} << 1 | {w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]} >> 31;
	assign tmp = {a_q[26:0], a_q[31:27]} + f + e_q + wnew + k;
	assign pos = {second_q, rd_idx_s1};
	assign byte_in = digest_q ? pad_byte(pos, rd_byte_s1, dn_q, bits_q, two_q) : rd_byte_s1;

	assign cmd_ready = (state_q == ST_IDLE);
	assign m_tvalid  = (state_q == ST_OUT);
	assign m_tlast   = (oidx_q == 3'd4);
	assign m_tdata   = work_h_q[oidx_q];

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready && cmd.req_type == sha1bs_pkg::REQ_DATA)
			buf_q[nbytes_q] <= cmd.data_byte;
		rd_byte_s1 <= buf_q[ld_q];
		rd_idx_s1  <= ld_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			nbytes_q <= '0;
			blocks_q <= '0;
			chain_q  <= {sha1bs_pkg::H4_INIT, sha1bs_pkg::H3_INIT, sha1bs_pkg::H2_INIT,
				sha1bs_pkg::H1_INIT, sha1bs_pkg::H0_INIT};
			t_q <= '0; ld_q <= '0; digest_q <= 1'b0; second_q <= 1'b0; two_q <= 1'b0;
			rd_vld_s1 <= 1'b0; oidx_q <= '0;
			work_h_q <= '0; w_q <= '0; dn_q <= '0; bits_q <= '0;
			a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.req_type)
							sha1bs_pkg::REQ_DATA: begin
								nbytes_q <= nbytes_q + 6'd1;
								if (nbytes_q == 6'd63) begin
									digest_q <= 1'b0; second_q <= 1'b0;
									work_h_q <= chain_q;
									ld_q <= '0; rd_vld_s1 <= 1'b0; t_q <= '0;
									state_q <= ST_LOAD;
								end
							end
							sha1bs_pkg::REQ_DIGEST: begin
								digest_q <= 1'b1; second_q <= 1'b0;
								two_q <= nbytes_q >= 6'd56;
								dn_q <= nbytes_q;
								bits_q <= {blocks_q, nbytes_q, 3'b000};
								work_h_q <= chain_q;
								ld_q <= '0; rd_vld_s1 <= 1'b0; t_q <= '0;
								state_q <= ST_LOAD;
							end
							sha1bs_pkg::REQ_RESTART: begin
								nbytes_q <= '0; blocks_q <= '0;
								chain_q <= {sha1bs_pkg::H4_INIT, sha1bs_pkg::H3_INIT,
									sha1bs_pkg::H2_INIT, sha1bs_pkg::H1_INIT, sha1bs_pkg::H0_INIT};
							end
							default: ;
						endcase
					end
				end
				ST_LOAD: begin
					// one byte per cycle through a registered read; shift into window
					rd_vld_s1 <= (ld_q != 6'd63) || !rd_vld_s1 || (rd_idx_s1 != 6'd63);
					if (ld_q != 6'd63) ld_q <= ld_q + 6'd1;
					if (rd_vld_s1) begin
						if (rd_idx_s1 == 6'd63) begin
							w_q <= {w_q[15][23:0], byte_in, w_q[14:0]};
							a_q <= work_h_q[0]; b_q <= work_h_q[1]; c_q <= work_h_q[2];
							d_q <= work_h_q[3]; e_q <= work_h_q[4];
							t_q <= '0;
							state_q <= ST_RND;
						end else if (rd_idx_s1[1:0] == 2'b11) begin
							w_q <= {32'h0, w_q[15][23:0], byte_in, w_q[14:1]};
						end else begin
							w_q[15] <= {w_q[15][23:0], byte_in};
						end
					end
				end
				ST_RND: begin
					w_q <= {wnew, w_q[15:1]};
					e_q <= d_q; d_q <= c_q; c_q <= {b_q[1:0], b_q[31:2]};
					b_q <= a_q; a_q <= tmp;
					t_q <= t_q + 7'd1;
					if (t_q == 7'd79) state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					work_h_q[0] <= work_h_q[0] + a_q;
					work_h_q[1] <= work_h_q[1] + b_q;
					work_h_q[2] <= work_h_q[2] + c_q;
					work_h_q[3] <= work_h_q[3] + d_q;
					work_h_q[4] <= work_h_q[4] + e_q;
					ld_q <= '0; rd_vld_s1 <= 1'b0;
					if (!digest_q) begin
						chain_q[0] <= work_h_q[0] + a_q;
						chain_q[1] <= work_h_q[1] + b_q;
						chain_q[2] <= work_h_q[2] + c_q;
						chain_q[3] <= work_h_q[3] + d_q;
						chain_q[4] <= work_h_q[4] + e_q;
						blocks_q <= blocks_q + 55'd1;
						state_q <= ST_IDLE;
					end else if (two_q && !second_q) begin
						second_q <= 1'b1;
						state_q <= ST_LOAD;
					end else begin
						oidx_q <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd4) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### hdl/sha1_byte_stream_hasher.sv
// SHA-1 byte stream hasher, top level.
// Channels: slave stream carries requests (tuser = request kind, tdata = byte);
// master stream carries digest words, tlast on the fifth word.
// A front queue of four entries decouples intake from the compression engine,
// so requests are taken while a block is compressed or a digest waits.
// Throughput: the engine takes one data byte per cycle while idle; every 64th
// byte adds a block pass (64 buffer reads, 80 rounds, one fold), set by the
// byte-serial block buffer read and the one-round-per-cycle datapath.
// A digest takes one block pass, or two when padding spills a block,
// then five output words.
// Reset (arst_n low) empties the queue, loads the initial chaining words and
// clears the counters; the block buffer keeps stale data that is never used.
// When the receiver stalls, the current word holds on the master side and the
// engine waits; new requests still queue until the front queue fills.
// Request kinds other than data, digest and restart are discarded.
// Depends on sha1bs_pkg, sha1bs_front, sha1bs_core.
module sha1_byte_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic        m_tlast
);
	logic cmd_valid, cmd_ready;
	sha1bs_pkg::cmd_t cmd;

	sha1bs_front u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.cmd_valid, .cmd_ready, .cmd
	);

	sha1bs_core u_core (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd,
		.m_tvalid, .m_tready, .m_tdata, .m_tlast
	);
endmodule

### bench/sha1_byte_stream_hasher_tb.sv
// Self-checking bench for the SHA-1 byte stream hasher.
// Predicts digest words in SystemVerilog and compares the output stream.
// Depends on sha1bs_pkg and sha1_byte_stream_hasher.
`timescale 1ns / 1ps

module sha1_byte_stream_hasher_tb;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] byte_val;
	} req_t;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} dig_t;

	localparam int STALL_LIMIT = 20000;
	// request code with no meaning; the block drops it
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic [1:0]  s_tuser;   // [1:0] req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [31:0] digest_word
	logic        m_tlast;

	sha1_byte_stream_hasher uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	req_t   pending_reqs[$];
	dig_t   digest_q[$];
	req_t   cur_req;
	int     send_idle_pct;
	int     recv_stall_pct;
	int     mismatches;
	int     quiet_cycles;
	bit     feed_done;

	// predictor state
	logic [31:0] chain[5];
	logic [7:0]  blk_buf[64];
	logic [5:0]  fill;
	logic [54:0] nblocks;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic logic [31:0] rol(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	task automatic sha1_compress(inout logic [31:0] h[5], input logic [7:0] b[128],
		input int base);
		logic [31:0] w[80];
		logic [31:0] a, bb, c, d, e, f, k, tmp;
		for (int t = 0; t < 16; t++)
			w[t] = {b[base+4*t], b[base+4*t+1], b[base+4*t+2], b[base+4*t+3]};
		for (int t = 16; t < 80; t++)
			w[t] = rol(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
		a = h[0]; bb = h[1]; c = h[2]; d = h[3]; e = h[4];
		for (int t = 0; t < 80; t++) begin
			if (t < 20) begin
				f = (bb & c) | (~bb & d); k = sha1bs_pkg::K0;
			end else if (t < 40) begin
				f = bb ^ c ^ d; k = sha1bs_pkg::K1;
			end else if (t < 60) begin
				f = (bb & c) | (bb & d) | (c & d); k = sha1bs_pkg::K2;
			end else begin
				f = bb ^ c ^ d; k = sha1bs_pkg::K3;
			end
			tmp = rol(a, 5) + f + e + w[t] + k;
			e = d; d = c; c = rol(bb, 30); bb = a; a = tmp;
		end
		h[0] += a; h[1] += bb; h[2] += c; h[3] += d; h[4] += e;
	endtask

	task automatic restart_chain();
		chain[0] = sha1bs_pkg::H0_INIT; chain[1] = sha1bs_pkg::H1_INIT;
		chain[2] = sha1bs_pkg::H2_INIT; chain[3] = sha1bs_pkg::H3_INIT;
		chain[4] = sha1bs_pkg::H4_INIT;
		fill = '0;
		nblocks = '0;
	endtask

	task automatic predict_digest(input req_t r);
		logic [7:0]  pad[128];
		logic [31:0] h[5];
		logic [63:0] bits;
		int          total;
		dig_t        d;
		if (r.kind == sha1bs_pkg::REQ_DATA) begin
			blk_buf[fill] = r.byte_val;
			fill = fill + 6'd1;
			if (fill == 6'd0) begin
				for (int i = 0; i < 128; i++) pad[i] = (i < 64) ? blk_buf[i] : 8'h00;
				sha1_compress(chain, pad, 0);
				nblocks = nblocks + 55'd1;
			end
		end else if (r.kind == sha1bs_pkg::REQ_RESTART) begin
			restart_chain();
		end else if (r.kind == sha1bs_pkg::REQ_DIGEST) begin
			for (int i = 0; i < 128; i++) pad[i] = (i < fill) ? blk_buf[i] : 8'h00;
			pad[fill] = sha1bs_pkg::PAD_BYTE;
			total = (fill < 56) ? 64 : 128;
			bits = {nblocks, fill, 3'b000};
			for (int i = 0; i < 8; i++) pad[total-8+i] = bits[63-8*i -: 8];
			h = chain;
			sha1_compress(h, pad, 0);
			if (total == 128) sha1_compress(h, pad, 64);
			for (int i = 0; i < 5; i++) begin
				d.word = h[i];
				d.last = (i == 4);
				digest_q.push_back(d);
			end
		end
	endtask

	function automatic req_t mk(input logic [1:0] kind, input logic [7:0] v);
		req_t r;
		r.kind = kind;
		r.byte_val = v;
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) predict_digest(cur_req);
			if (!s_tvalid || s_tready) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_req = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= cur_req.kind;
					s_tdata  <= cur_req.byte_val;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		dig_t exp_d;
		if (!arst_n) begin
			m_tready <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (m_tvalid && m_tready) begin
				if (digest_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected digest word %h last %b", m_tdata, m_tlast);
				end else begin
					exp_d = digest_q.pop_front();
					if (exp_d.word !== m_tdata || exp_d.last !== m_tlast) begin
						mismatches++;
						if (mismatches <= 10)
							$display("digest mismatch: exp %h/%b got %h/%b",
								exp_d.word, exp_d.last, m_tdata, m_tlast);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic add_random(input int n);
		int   run_len;
		int   r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 78) begin
				run_len = $urandom_range(1, 3);
				for (int j = 0; j < run_len; j++)
					pending_reqs.push_back(mk(sha1bs_pkg::REQ_DATA, 8'($urandom())));
			end else if (r < 92) begin
				pending_reqs.push_back(mk(sha1bs_pkg::REQ_DIGEST, 8'($urandom())));
			end else if (r < 97) begin
				pending_reqs.push_back(mk(sha1bs_pkg::REQ_RESTART, 8'($urandom())));
			end else begin
				pending_reqs.push_back(mk(REQ_UNUSED, 8'($urandom())));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		for (int i = 0; i < 64; i++) blk_buf[i] = 8'h00;
		restart_chain();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty message, ignored code, extremes, restart
		pending_reqs.push_back(mk(sha1bs_pkg::REQ_DIGEST, 8'h00));
		pending_reqs.push_back(mk(REQ_UNUSED, 8'hff));
		pending_reqs.push_back(mk(sha1bs_pkg::REQ_DATA, 8'h00));
		pending_reqs.push_back(mk(sha1bs_pkg::REQ_DATA, 8'hff));
		pending_reqs.push_back(mk(sha1bs_pkg::REQ_DIGEST, 8'hff));
		pending_reqs.push_back(mk(sha1bs_pkg::REQ_RESTART, 8'h55));
		pending_reqs.push_back(mk(sha1bs_pkg::REQ_DATA, 8'h61));
		pending_reqs.push_back(mk(sha1bs_pkg::REQ_DATA, 8'h62));
		pending_reqs.push_back(mk(sha1bs_pkg::REQ_DATA, 8'h63));
		pending_reqs.push_back(mk(sha1bs_pkg::REQ_DIGEST, 8'haa));
		pending_reqs.push_back(mk(sha1bs_pkg::REQ_RESTART, 8'h00));

		// four phases with different sender idle and receiver stall rates; each adds random traffic then drains
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
				default: begin send_idle_pct = 9; recv_stall_pct = 9; end
			endcase
			if (ph == 0) begin
				// padding spills into a second block, then a full block at fill zero
				for (int j = 0; j < 60; j++)
					pending_reqs.push_back(mk(sha1bs_pkg::REQ_DATA, 8'($urandom())));
				pending_reqs.push_back(mk(sha1bs_pkg::REQ_DIGEST, 8'h00));
				for (int j = 0; j < 4; j++)
					pending_reqs.push_back(mk(sha1bs_pkg::REQ_DATA, 8'($urandom())));
				pending_reqs.push_back(mk(sha1bs_pkg::REQ_DIGEST, 8'h00));
			end
			add_random(7);
			pending_reqs.push_back(mk(sha1bs_pkg::REQ_DIGEST, 8'h00));
			while (pending_reqs.size() > 0 || s_tvalid || digest_q.size() > 0)
				@(posedge clk);
		end
		repeat (400) @(posedge clk);

		if (mismatches == 0 && digest_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

### sha1_byte_stream_hasher.f
hdl/sha1bs_pkg.sv
hdl/sha1bs_front.sv
hdl/sha1bs_core.sv
hdl/sha1_byte_stream_hasher.sv
bench/sha1_byte_stream_hasher_tb.sv
